[rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/hcu_pkg.sv]
`timescale 1ns / 1ps
package hcu_pkg;

	// One letter of the 26-letter alphabet, 0 for a.
	typedef logic [4:0] sym_t;
	// Four key entries: 0 top left, 1 top right, 2 bottom left, 3 bottom right.
	typedef logic [3:0][4:0] key_mat_t;

	// One unit of work for the back end: a letter pair or a single marker beat.
	typedef struct packed {
		logic marker;
		logic dir;
		sym_t p0;
		sym_t p1;
		logic done;
		logic err;
	} job_t;

	typedef struct packed {
		logic busy;
		logic ok;
	} inv_stat_t;

	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UZ = 8'h5A;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LZ = 8'h7A;
	localparam sym_t PAD_SYM = 5'd25;
	localparam logic [5:0] ALPHA = 6'd26;
	// 2521 / 65536 is just above 1/26; exact floor for values below 2048.
	localparam logic [11:0] RECIP_26 = 12'd2521;

	localparam logic [2:0] REG_KEY_TL = 3'd0;
	localparam logic [2:0] REG_KEY_TR = 3'd1;
	localparam logic [2:0] REG_KEY_BL = 3'd2;
	localparam logic [2:0] REG_KEY_BR = 3'd3;
	localparam logic [2:0] REG_DIR    = 3'd4;

	// Residue mod 26 of an 11-bit value by reciprocal multiplication.
	function automatic sym_t mod26_f(input logic [10:0] x);
		logic [22:0] prod;
		logic [6:0]  q;
		logic [10:0] r;
		prod = 23'(x) * 23'(RECIP_26);
		q    = prod[22:16];
		r    = x - 11'(q) * 11'(ALPHA);
		return r[4:0];
	endfunction

	// Residue mod 26 of a 5-bit value.
	function automatic sym_t fold26_f(input logic [4:0] x);
		return (x >= 5'(ALPHA)) ? x - 5'(ALPHA) : x;
	endfunction

	// Multiplicative inverse mod 26; zero where none exists.
	function automatic sym_t dinv_f(input sym_t det);
		sym_t r;
		unique case (det)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/hill_cipher_2x2_mod26_unit.sv]
`timescale 1ns / 1ps
// 2x2 Hill cipher over the 26-letter alphabet. One character is accepted per clock while in_stall
// is low; letters are case-folded, everything else is dropped, and each completed letter pair
// leaves as two result beats in turn (upper case when encrypting, lower case when decrypting),
// while a message end with nothing to pair, a dropped odd letter when decrypting, or a pair
// decrypted under a key with no inverse leaves as a single beat with letter_valid low. The front
// end classifies characters and pairs letters at the full input rate; a queue of QUEUE_DEPTH
// jobs decouples it from the back end, whose three-stage multiply and mod-26 pipeline emits one
// beat per cycle while out_stall is low, so a stream of letters is sustained at one character
// per cycle, and a pair's job passes through the queue and each pipeline stage before its first
// beat is offered. Writing any key register starts a recomputation of the inverse matrix
// (products, determinant, inverse, scaling, reduction), during which in_stall is held high; a
// direction write takes effect on the next cycle. There is no clearing pass after reset.
`include "assert_macros.svh"
module hill_cipher_2x2_mod26_unit
	import hcu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       message_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] letter_code,
	output logic       letter_valid,
	output logic       run_last,
	output logic       message_done,
	output logic       key_error
);

	key_mat_t  key_q;
	logic      dir_q;
	logic      key_wr;
	key_mat_t  inv_mat;
	inv_stat_t inv_stat;
	logic      accept;
	logic      push;
	job_t      job;
	job_t      job_head;
	logic      empty;
	logic      full;
	logic      pop;
	logic      pair_first;

	// A key write restarts the inverse computation; the direction bit needs none.
	always_comb begin
		key_wr = 1'b0;
		unique case (cfg_index)
			REG_KEY_TL, REG_KEY_TR, REG_KEY_BL, REG_KEY_BR: key_wr = cfg_we;
			default: key_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= {5'd5, 5'd2, 5'd3, 5'd3};
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			if (key_wr) begin
				key_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index == REG_DIR) begin
				dir_q <= cfg_data[0];
			end
		end
	end

	// Input is held off while the queue is full or the inverse key is being rebuilt.
	assign in_stall = full || inv_stat.busy;
	assign accept   = in_valid && !in_stall;

	hcu_inv u_inv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (key_wr),
		.key_mat (key_q),
		.inv_mat (inv_mat),
		.stat    (inv_stat)
	);

	hcu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_code   (char_code),
		.message_end (message_end),
		.dir         (dir_q),
		.inv_ok      (inv_stat.ok),
		.push        (push),
		.job         (job)
	);

	hcu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job),
		.pop    (pop),
		.dout   (job_head),
		.empty  (empty),
		.full   (full)
	);

	hcu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_mat      (key_q),
		.inv_mat      (inv_mat),
		.job_in       (job_head),
		.job_avail    (!empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.letter_code  (letter_code),
		.letter_valid (letter_valid),
		.run_last     (run_last),
		.message_done (message_done),
		.key_error    (key_error)
	);

	// The first beat of a pair being taken by the receiver.
	assign pair_first = out_valid && !out_stall && !run_last;

	// A beat without a letter is always the only beat of its job.
	`ASSERT_IMP(a_marker_last, clk, arst_n, out_valid && !letter_valid, run_last)
	// An error beat never carries a letter.
	`ASSERT_IMP(a_err_no_letter, clk, arst_n, out_valid && key_error, !letter_valid)
	// The first beat of a pair is followed at once by its closing letter beat.
	`ASSERT_NEXT(a_pair_second, clk, arst_n, pair_first, out_valid && letter_valid && run_last)
	// The front end never pushes into a full queue.
	`ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)

endmodule

[rtl/hcu_fifo.sv]
`timescale 1ns / 1ps
module hcu_fifo
	import hcu_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t dout,
	output logic empty,
	output logic full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/hcu_front.sv]
`timescale 1ns / 1ps
module hcu_front
	import hcu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       message_end,
	input  logic       dir,
	input  logic       inv_ok,
	output logic       push,
	output job_t       job
);

	sym_t       held_q;
	logic       held_v_q;
	logic       is_upper;
	logic       is_lower;
	logic       is_letter;
	logic [7:0] off;
	sym_t       sym;
	sym_t       new_held;
	logic       new_held_v;
	logic       pair_now;

	assign is_upper  = (char_code >= CHAR_UA) && (char_code <= CHAR_UZ);
	assign is_lower  = (char_code >= CHAR_LA) && (char_code <= CHAR_LZ);
	assign is_letter = is_upper || is_lower;
	assign off       = char_code - (is_upper ? CHAR_UA : CHAR_LA);
	assign sym       = off[4:0];

	assign pair_now   = is_letter && held_v_q;
	assign new_held   = is_letter ? sym : held_q;
	assign new_held_v = is_letter || held_v_q;

	always_comb begin
		job.marker = 1'b0;
		job.dir    = dir;
		job.p0     = held_q;
		job.p1     = sym;
		job.done   = message_end;
		job.err    = 1'b0;
		push       = 1'b0;
		if (pair_now) begin
			push = accept;
			// Decrypting with a singular key yields one error beat per pair.
			if (dir && !inv_ok) begin
				job.marker = 1'b1;
				job.err    = 1'b1;
			end
		end else if (message_end) begin
			push     = accept;
			job.done = 1'b1;
			if (!new_held_v) begin
				job.marker = 1'b1;
			end else if (dir) begin
				job.marker = 1'b1;
				job.err    = 1'b1;
			end else begin
				job.p0 = new_held;
				job.p1 = PAD_SYM;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_letter) begin
			held_q <= sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
		end else if (accept) begin
			held_v_q <= (pair_now || message_end) ? 1'b0 : new_held_v;
		end
	end

endmodule

[rtl/hcu_inv.sv]
`timescale 1ns / 1ps
module hcu_inv
	import hcu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  key_mat_t  key_mat,
	output key_mat_t  inv_mat,
	output inv_stat_t stat
);

	localparam logic [2:0] INV_IDLE = 3'd0;
	localparam logic [2:0] INV_PROD = 3'd1;
	localparam logic [2:0] INV_DET  = 3'd2;
	localparam logic [2:0] INV_DINV = 3'd3;
	localparam logic [2:0] INV_MUL  = 3'd4;
	localparam logic [2:0] INV_RED  = 3'd5;

	logic [2:0]  state_q;
	logic [9:0]  ad_q;
	logic [9:0]  bc_q;
	sym_t        det_q;
	sym_t        dinv_q;
	logic [9:0]  prod_q [4];
	key_mat_t    inv_q;
	logic        ok_q;

	sym_t        a;
	sym_t        b;
	sym_t        c;
	sym_t        d;
	sym_t        ma;
	sym_t        mb;
	logic [5:0]  diff;
	sym_t        det;
	sym_t        nb;
	sym_t        nc;

	assign a    = fold26_f(key_mat[0]);
	assign b    = fold26_f(key_mat[1]);
	assign c    = fold26_f(key_mat[2]);
	assign d    = fold26_f(key_mat[3]);
	assign nb   = (b == '0) ? '0 : 5'(ALPHA) - b;
	assign nc   = (c == '0) ? '0 : 5'(ALPHA) - c;
	assign ma   = mod26_f(11'(ad_q));
	assign mb   = mod26_f(11'(bc_q));
	assign diff = {1'b0, ma} + ALPHA - {1'b0, mb};
	assign det  = (diff >= ALPHA) ? 5'(diff - ALPHA) : diff[4:0];

	assign inv_mat = inv_q;
	assign stat.busy = (state_q != INV_IDLE);
	assign stat.ok   = ok_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			INV_PROD: begin
				ad_q <= 10'(a) * 10'(d);
				bc_q <= 10'(b) * 10'(c);
			end
			INV_DET:  det_q  <= det;
			INV_DINV: dinv_q <= dinv_f(det_q);
			INV_MUL: begin
				prod_q[0] <= 10'(d) * 10'(dinv_q);
				prod_q[1] <= 10'(nb) * 10'(dinv_q);
				prod_q[2] <= 10'(nc) * 10'(dinv_q);
				prod_q[3] <= 10'(a) * 10'(dinv_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= INV_IDLE;
			inv_q   <= {5'd9, 5'd20, 5'd17, 5'd15};
			ok_q    <= 1'b1;
		end else if (start) begin
			state_q <= INV_PROD;
		end else begin
			unique case (state_q)
				INV_IDLE: state_q <= INV_IDLE;
				INV_PROD: state_q <= INV_DET;
				INV_DET:  state_q <= INV_DINV;
				INV_DINV: state_q <= INV_MUL;
				INV_MUL:  state_q <= INV_RED;
				INV_RED: begin
					state_q <= INV_IDLE;
					ok_q    <= (dinv_q != '0);
					for (int i = 0; i < 4; i++) begin
						inv_q[i] <= mod26_f(11'(prod_q[i]));
					end
				end
				default: state_q <= INV_IDLE;
			endcase
		end
	end

endmodule

[rtl/hcu_back.sv]
`timescale 1ns / 1ps
module hcu_back
	import hcu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  key_mat_t   key_mat,
	input  key_mat_t   inv_mat,
	input  job_t       job_in,
	input  logic       job_avail,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] letter_code,
	output logic       letter_valid,
	output logic       run_last,
	output logic       message_done,
	output logic       key_error
);

	logic        v_s1;
	job_t        job_s1;
	logic [9:0]  pr_s1 [4];
	logic        v_s2;
	job_t        job_s2;
	logic [10:0] sum_s2 [2];
	logic [6:0]  q_s2 [2];
	logic        v_s3;
	logic        marker_s3;
	logic        done_s3;
	logic        err_s3;
	logic [7:0]  let_s3 [2];
	logic        beat_q;

	key_mat_t    m;
	logic [10:0] sum [2];
	logic [22:0] qp [2];
	logic [10:0] rem [2];
	logic [7:0]  base;
	logic        take;
	logic        final_beat;
	logic        adv;

	assign m          = job_in.dir ? inv_mat : key_mat;
	assign take       = v_s3 && !out_stall;
	assign final_beat = marker_s3 || beat_q;
	assign adv        = !v_s3 || (take && final_beat);
	assign pop        = adv && job_avail;
	assign base       = job_s2.dir ? CHAR_LA : CHAR_UA;

	always_comb begin
		sum[0] = 11'(pr_s1[0]) + 11'(pr_s1[1]);
		sum[1] = 11'(pr_s1[2]) + 11'(pr_s1[3]);
		for (int i = 0; i < 2; i++) begin
			qp[i]  = 23'(sum[i]) * 23'(RECIP_26);
			rem[i] = sum_s2[i] - 11'(q_s2[i]) * 11'(ALPHA);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1    <= job_in;
			pr_s1[0]  <= 10'(m[0]) * 10'(job_in.p0);
			pr_s1[1]  <= 10'(m[1]) * 10'(job_in.p1);
			pr_s1[2]  <= 10'(m[2]) * 10'(job_in.p0);
			pr_s1[3]  <= 10'(m[3]) * 10'(job_in.p1);
			job_s2    <= job_s1;
			marker_s3 <= job_s2.marker;
			done_s3   <= job_s2.done;
			err_s3    <= job_s2.err;
			for (int i = 0; i < 2; i++) begin
				sum_s2[i] <= sum[i];
				q_s2[i]   <= qp[i][22:16];
				let_s3[i] <= base + 8'(rem[i][4:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			beat_q <= 1'b0;
		end else if (adv) begin
			v_s1   <= pop;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			beat_q <= 1'b0;
		end else if (take) begin
			beat_q <= 1'b1;
		end
	end

	always_comb begin
		out_valid    = v_s3;
		letter_code  = beat_q ? let_s3[1] : let_s3[0];
		letter_valid = 1'b1;
		run_last     = beat_q;
		message_done = beat_q && done_s3;
		key_error    = 1'b0;
		if (marker_s3) begin
			letter_code  = 8'h00;
			letter_valid = 1'b0;
			run_last     = 1'b1;
			message_done = done_s3;
			key_error    = err_s3;
		end
	end

endmodule

[tb/hill_cipher_2x2_mod26_unit_test.sv]
`timescale 1ns / 1ps
module hill_cipher_2x2_mod26_unit_test;
	import hcu_pkg::*;

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [7:0] letter_code;
		logic       letter_valid;
		logic       run_last;
		logic       message_done;
		logic       key_error;
	} letter_beat_t;

	// A directed row either offers one character or writes one register.
	typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [2:0]   reg_idx;
		logic [4:0]   reg_val;
		logic [7:0]   ch;
		logic         fin;
		logic         typed;
		logic [1:0]   count;
		letter_beat_t b0;
		letter_beat_t b1;
	} script_row_t;

	localparam int GAP_PERCENT   = 11;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 94;
	localparam int SETTLE_CYCLES = 8;
	localparam int WRITE_GAP     = 10;

	// Beats that can be read straight off the cipher definition.
	localparam letter_beat_t NIL      = '0;
	localparam letter_beat_t T_BEAT   = '{"T", 1'b1, 1'b0, 1'b0, 1'b0};
	localparam letter_beat_t C_LAST   = '{"C", 1'b1, 1'b1, 1'b0, 1'b0};
	localparam letter_beat_t X_BEAT   = '{"X", 1'b1, 1'b0, 1'b0, 1'b0};
	localparam letter_beat_t V_DONE   = '{"V", 1'b1, 1'b1, 1'b1, 1'b0};
	localparam letter_beat_t H_BEAT   = '{"h", 1'b1, 1'b0, 1'b0, 1'b0};
	localparam letter_beat_t I_LAST   = '{"i", 1'b1, 1'b1, 1'b0, 1'b0};
	localparam letter_beat_t MARKER   = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
	localparam letter_beat_t ERR_DONE = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
	localparam letter_beat_t ERR_PAIR = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};

	// The directed script starts from the reset key (3 3 / 2 5) in encrypt mode. HI under that
	// key is the textbook TC, and TC decrypts back to hi.
	localparam script_row_t SCRIPT [27] = '{
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "H",   1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "I",   1'b0, 1'b1, 2'd2, T_BEAT,   C_LAST},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, 8'h00, 1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, 8'hFF, 1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, 8'h40, 1'b1, 1'b1, 2'd1, MARKER,   NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "a",   1'b1, 1'b1, 2'd2, X_BEAT,   V_DONE},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "z",   1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "Z",   1'b1, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, 8'h5B, 1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, 8'h60, 1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "A",   1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, 8'h7B, 1'b1, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "k",   1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_WRITE, REG_DIR,    5'd1, 8'h00, 1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "m",   1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "t",   1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "c",   1'b0, 1'b1, 2'd2, H_BEAT,   I_LAST},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "Q",   1'b1, 1'b1, 2'd1, ERR_DONE, NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, 8'h80, 1'b1, 1'b1, 2'd1, MARKER,   NIL},
		'{ROW_WRITE, REG_KEY_TL, 5'd0, 8'h00, 1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "a",   1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "b",   1'b0, 1'b1, 2'd1, ERR_PAIR, NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "c",   1'b0, 1'b1, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "d",   1'b1, 1'b1, 2'd1, ERR_DONE, NIL},
		'{ROW_WRITE, REG_DIR,    5'd0, 8'h00, 1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "a",   1'b0, 1'b0, 2'd0, NIL,      NIL},
		'{ROW_BEAT,  REG_KEY_TL, 5'd0, "b",   1'b1, 1'b0, 2'd0, NIL,      NIL}
	};

	// Key settings for the first random phases, written bottom right first as the packed type
	// holds them: an all-zero key, all 25, all 31 (residue 5, singular), minus the identity,
	// and one mixing 31 and 26 that is invertible.
	localparam key_mat_t PRESET_KEYS [5] = '{
		{5'd0, 5'd0, 5'd0, 5'd0},
		{5'd25, 5'd25, 5'd25, 5'd25},
		{5'd31, 5'd31, 5'd31, 5'd31},
		{5'd25, 5'd0, 5'd0, 5'd25},
		{5'd1, 5'd0, 5'd26, 5'd31}
	};
	localparam logic PRESET_DIR [5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_KEY_TL;
	logic [4:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = '0;
	logic       message_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] letter_code;
	logic       letter_valid;
	logic       run_last;
	logic       message_done;
	logic       key_error;

	// Our own copy of the cipher state and configuration.
	key_mat_t key_now;
	logic     decrypting;
	sym_t     lone_sym;
	logic     lone_held;
	key_mat_t key_inv;
	logic     key_inv_ok;

	letter_beat_t letters_due[$];
	int faults = 0;

	// Idling controls and the long receiver hold-off, which is requested by the stimulus and
	// counted out by the receiver process alone.
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	hill_cipher_2x2_mod26_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("hill_cipher_2x2_mod26_unit verification failed");
		$finish;
	end

	// Works out the inverse of a key mod 26 by searching for the inverse of its determinant.
	// Returns 0 and an all-zero matrix when the determinant shares a factor with 26.
	function automatic bit invert_key(input key_mat_t k, output key_mat_t inv);
		int a, b, c, d, det, dinv;
		a = k[0] % 26;
		b = k[1] % 26;
		c = k[2] % 26;
		d = k[3] % 26;
		det = (a * d - b * c) % 26;
		if (det < 0)
			det += 26;
		dinv = 0;
		for (int x = 25; x >= 1; x--)
			if ((det * x) % 26 == 1)
				dinv = x;
		inv = '0;
		if (dinv == 0)
			return 1'b0;
		inv[0] = 5'((d * dinv) % 26);
		inv[1] = 5'((((26 - b) % 26) * dinv) % 26);
		inv[2] = 5'((((26 - c) % 26) * dinv) % 26);
		inv[3] = 5'((a * dinv) % 26);
		return 1'b1;
	endfunction

	// Case folding: tells whether a byte is a letter and, if so, its place in the alphabet.
	function automatic bit letter_of(input logic [7:0] ch, output sym_t v);
		v = '0;
		if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
			v = sym_t'(ch - CHAR_UA);
			return 1'b1;
		end
		if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
			v = sym_t'(ch - CHAR_LA);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Multiplies a letter pair by the key, or by its inverse when decrypting (an error beat if none).
	function automatic int cipher_pair(input sym_t p0, input sym_t p1, input logic fin,
			output letter_beat_t b0, output letter_beat_t b1);
		key_mat_t m;
		logic [7:0] base;
		b0 = '0;
		b1 = '0;
		if (decrypting) begin
			if (!key_inv_ok) begin
				b0 = '{8'h00, 1'b0, 1'b1, fin, 1'b1};
				return 1;
			end
			m = key_inv;
			base = CHAR_LA;
		end else begin
			m = key_now;
			base = CHAR_UA;
		end
		b0 = '{base + 8'((m[0] * p0 + m[1] * p1) % 26), 1'b1, 1'b0, 1'b0, 1'b0};
		b1 = '{base + 8'((m[2] * p0 + m[3] * p1) % 26), 1'b1, 1'b1, fin, 1'b0};
		return 2;
	endfunction

	// Advances the cipher state by one character and returns the beats it gives rise to.
	function automatic int advance_cipher(input logic [7:0] ch, input logic fin,
			output letter_beat_t b0, output letter_beat_t b1);
		sym_t v;
		b0 = '0;
		b1 = '0;
		if (letter_of(ch, v)) begin
			if (lone_held) begin
				lone_held = 1'b0;
				return cipher_pair(lone_sym, v, fin, b0, b1);
			end
			lone_sym = v;
			lone_held = 1'b1;
		end
		if (!fin)
			return 0;
		// Nothing waiting for a partner: the message end leaves as a bare marker.
		if (!lone_held) begin
			b0 = MARKER;
			return 1;
		end
		lone_held = 1'b0;
		// An odd letter is dropped with an error when decrypting, and padded when encrypting.
		if (decrypting) begin
			b0 = ERR_DONE;
			return 1;
		end
		return cipher_pair(lone_sym, PAD_SYM, 1'b1, b0, b1);
	endfunction

	function automatic string beat_text(input letter_beat_t b);
		return $sformatf("code %h valid %b last %b done %b error %b", b.letter_code,
			b.letter_valid, b.run_last, b.message_done, b.key_error);
	endfunction

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 99) < 15)
			return 8'($urandom_range(0, 255));
		return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'($urandom_range(0, 25));
	endfunction

	task automatic note_fault(input string what);
		faults++;
		if (faults <= 10)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Offers one character and waits for it to be taken. The stall is sampled at the falling
	// edge, where it is settled for the rising edge that follows. Directed rows with a typed
	// expectation push that instead of the predicted beats, though the prediction still runs
	// so that our copy of the state moves on.
	task automatic offer_char(input logic [7:0] ch, input logic fin, input bit typed = 1'b0,
			input int typed_n = 0, input letter_beat_t tb0 = '0,
			input letter_beat_t tb1 = '0);
		logic blocked;
		letter_beat_t b0, b1;
		int n;
		while (tx_gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= ch;
		message_end <= fin;
		do begin
			@(negedge clk);
			blocked = in_stall;
			@(posedge clk);
		end while (blocked);
		n = advance_cipher(ch, fin, b0, b1);
		if (typed) begin
			n = typed_n;
			b0 = tb0;
			b1 = tb1;
		end
		if (n > 0)
			letters_due.push_back(b0);
		if (n > 1)
			letters_due.push_back(b1);
	endtask

	// Lets the block drain: no more input, every expected beat out, then a wait for anything
	// still working its way through the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		while (letters_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A key write starts a recomputation of the inverse inside the block, so writes are spaced
	// out well beyond it.
	task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIR) begin
			decrypting = value[0];
		end else begin
			key_now[idx[1:0]] = value;
			key_inv_ok = invert_key(key_now, key_inv);
		end
		repeat (WRITE_GAP) @(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off when one has been requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			out_stall <= rx_gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
		end
	end

	// Checker: a beat is taken at the rising edge after this falling edge if valid is high
	// and we are not stalling; it must match the oldest expectation field for field.
	always @(negedge clk) begin
		letter_beat_t seen, want;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{letter_code, letter_valid, run_last, message_done, key_error};
			if (letters_due.size() == 0) begin
				note_fault($sformatf("unexpected beat, %s", beat_text(seen)));
			end else begin
				want = letters_due.pop_front();
				if (seen !== want)
					note_fault($sformatf("expected %s, got %s", beat_text(want),
						beat_text(seen)));
			end
		end
	end

	initial begin
		key_mat_t keys, scratch;
		logic dir, fin, want_inv;
		logic [7:0] ch;
		int counted, len, tries;

		key_now = {5'd5, 5'd2, 5'd3, 5'd3};
		decrypting = 1'b0;
		lone_sym = '0;
		lone_held = 1'b0;
		key_inv_ok = invert_key(key_now, key_inv);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: boundary characters, padding, the odd-letter drop, bare markers,
		// a direction change with a letter still held, and a singular key in both modes.
		foreach (SCRIPT[r]) begin
			if (SCRIPT[r].kind == ROW_WRITE) begin
				settle();
				write_reg(SCRIPT[r].reg_idx, SCRIPT[r].reg_val);
			end else begin
				offer_char(SCRIPT[r].ch, SCRIPT[r].fin, SCRIPT[r].typed, SCRIPT[r].count,
					SCRIPT[r].b0, SCRIPT[r].b1);
			end
		end

		// Random part, in phases with a fresh key and direction each. Most traffic is whole
		// messages of mostly letters; the rest is loose bytes with a random end mark.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 5) begin
				keys = PRESET_KEYS[phase];
				dir = PRESET_DIR[phase];
			end else begin
				dir = 1'($urandom_range(0, 1));
				// Decrypting is mostly done with a key that has an inverse, else nearly every
				// pair would come back as a key error.
				want_inv = dir && ($urandom_range(0, 3) != 0);
				tries = 0;
				do begin
					for (int i = 0; i < 4; i++)
						keys[i] = 5'($urandom_range(0, 31));
					tries++;
				end while (want_inv && !invert_key(keys, scratch) && tries < 50);
			end

			settle();
			write_reg(REG_KEY_TL, keys[0]);
			write_reg(REG_KEY_TR, keys[1]);
			write_reg(REG_KEY_BL, keys[2]);
			write_reg(REG_KEY_BR, keys[3]);
			write_reg(REG_DIR, 5'(dir));

			// One phase sees the receiver hold off for a long while so that the queue fills
			// and the input is stalled; two others run without any idling at all.
			if (phase == 5)
				hold_requests <= hold_requests + 1;
			tx_gaps_on <= (phase != 7 && phase != 8);
			rx_gaps_on <= (phase != 7 && phase != 8);

			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 8) begin
					len = $urandom_range(0, 11);
					for (int k = 0; k <= len; k++) begin
						ch = pick_char();
						offer_char(ch, k == len);
						counted++;
					end
				end else begin
					ch = 8'($urandom_range(0, 255));
					fin = ($urandom_range(0, 3) == 0);
					offer_char(ch, fin);
					counted++;
				end
			end

			// Now and then a letter is left waiting across the next configuration change.
			if ($urandom_range(0, 1))
				offer_char(CHAR_UA + 8'($urandom_range(0, 25)), 1'b0);
		end

		settle();
		if (faults == 0)
			$display("hill_cipher_2x2_mod26_unit verification clean");
		else
			$display("hill_cipher_2x2_mod26_unit verification failed");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/hcu_pkg.sv
rtl/hcu_fifo.sv
rtl/hcu_front.sv
rtl/hcu_inv.sv
rtl/hcu_back.sv
rtl/hill_cipher_2x2_mod26_unit.sv
tb/hill_cipher_2x2_mod26_unit_test.sv
